FILE: hw/rtl/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

   // Request command codes.
   localparam logic COMMAND_START = 1'b0;
   localparam logic COMMAND_STEP  = 1'b1;

   // Operand pairs for the shared multiplier.
   typedef enum logic [2:0] {
      MUL_RX_SQ,
      MUL_RY_SQ,
      MUL_RX2_RY,
      MUL_TX_SQ,
      MUL_RY2_PROD,
      MUL_YM_SQ,
      MUL_RX2_PROD,
      MUL_RX2_RY2
   } mul_sel_type;

   // What the datapath does with the product registered in the previous cycle.
   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_SAVE_RX2,
      ACC_SAVE_RY2,
      ACC_INIT_R1,
      ACC_LOAD_DEC,
      ACC_ADD_DEC,
      ACC_SUB_DEC
   } acc_op_type;

   // Controller to datapath.
   typedef struct packed {
      logic        load_start;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        step_r1;
      logic        step_r2;
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic x_below_y;
      logic y_exhausted;
      logic out_free;
   } dp_status_type;

endpackage

FILE: hw/rtl/mer_req_if.sv
// Request channel: command and ellipse geometry.
interface mer_req_if #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
);
   logic                   valid;
   logic                   ready;
   logic                   command;
   logic [RADIUS_BITS-1:0] radius_x;
   logic [RADIUS_BITS-1:0] radius_y;
   logic [COORD_BITS-1:0]  centre_x;
   logic [COORD_BITS-1:0]  centre_y;

   modport source (output valid, command, radius_x, radius_y, centre_x, centre_y,
                   input ready);
   modport sink   (input valid, command, radius_x, radius_y, centre_x, centre_y,
                   output ready);
endinterface

FILE: hw/rtl/mer_rsp_if.sv
// Response channel: the four mirrored pixel coordinates of one point.
interface mer_rsp_if #(
   parameter int COORD_BITS = 11
);
   logic                        valid;
   logic                        ready;
   logic signed [COORD_BITS+1:0] px_right;
   logic signed [COORD_BITS+1:0] px_left;
   logic signed [COORD_BITS+1:0] py_lower;
   logic signed [COORD_BITS+1:0] py_upper;
   logic                        last_point;

   modport source (output valid, px_right, px_left, py_lower, py_upper, last_point,
                   input ready);
   modport sink   (input valid, px_right, px_left, py_lower, py_upper, last_point,
                   output ready);
endinterface

FILE: hw/rtl/mer_datapath.sv
// Datapath: held geometry, walk state, shared multiplier and output register.
module mer_datapath #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mer_pkg::dp_cmd_type           cmd,
   output mer_pkg::dp_status_type        status,
   input  logic [RADIUS_BITS-1:0]        req_radius_x,
   input  logic [RADIUS_BITS-1:0]        req_radius_y,
   input  logic [COORD_BITS-1:0]         req_centre_x,
   input  logic [COORD_BITS-1:0]         req_centre_y,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_BITS+1:0]  rsp_px_right,
   output logic signed [COORD_BITS+1:0]  rsp_px_left,
   output logic signed [COORD_BITS+1:0]  rsp_py_lower,
   output logic signed [COORD_BITS+1:0]  rsp_py_upper,
   output logic                          rsp_last_point
);

   localparam int OUT_BITS = COORD_BITS + 2;
   localparam int CUR_BITS = RADIUS_BITS + 2;
   localparam int SQ_BITS  = 2 * RADIUS_BITS;
   localparam int MB_BITS  = 2 * RADIUS_BITS + 6;
   localparam int DEC_BITS = (4 * RADIUS_BITS + 8 > 64) ? 64 : 4 * RADIUS_BITS + 8;
   localparam int SUM_BITS = (OUT_BITS > CUR_BITS) ? OUT_BITS : CUR_BITS;

   // Held geometry.
   logic [RADIUS_BITS-1:0] rad_x_ff, rad_y_ff;
   logic [COORD_BITS-1:0]  cen_x_ff, cen_y_ff;
   logic [SQ_BITS-1:0]     rx2_ff, ry2_ff;

   // Walk state.
   logic [CUR_BITS-1:0]        cur_x_ff;
   logic signed [CUR_BITS-1:0] cur_y_ff;
   logic [DEC_BITS-1:0]        step_x_ff, step_y_ff, dec_ff, prod_ff;

   // Output register.
   logic                       out_valid_ff;
   logic signed [OUT_BITS-1:0] out_right_ff, out_left_ff, out_lower_ff, out_upper_ff;
   logic                       out_last_ff;

   logic [SQ_BITS-1:0]      mul_a;
   logic [MB_BITS-1:0]      mul_b;
   logic [DEC_BITS-1:0]     mul_p;
   logic [CUR_BITS:0]       tx;
   logic signed [CUR_BITS:0] ym;
   logic [CUR_BITS-1:0]     ym_abs;
   logic [DEC_BITS-1:0]     rx2_ext, ry2_ext, sx_next, sy_next;
   logic [DEC_BITS-1:0]     dec_r1_up, dec_r1_diag, dec_r2_down, dec_r2_diag;
   logic                    dec_neg, dec_pos, out_free;
   logic [SUM_BITS-1:0]     sum_right, sum_left, sum_lower, sum_upper;

   // Region-2 operands: 2x+1 and the magnitude of y-1.
   assign tx     = {cur_x_ff, 1'b1};
   assign ym     = (CUR_BITS + 1)'(cur_y_ff) - (CUR_BITS + 1)'(1);
   assign ym_abs = ym[CUR_BITS] ? CUR_BITS'(-ym) : ym[CUR_BITS-1:0];

   // Shared multiplier operand selection.
   always_comb begin
      case (cmd.mul_sel)
         mer_pkg::MUL_RX_SQ: begin
            mul_a = SQ_BITS'(rad_x_ff);
            mul_b = MB_BITS'(rad_x_ff);
         end
         mer_pkg::MUL_RY_SQ: begin
            mul_a = SQ_BITS'(rad_y_ff);
            mul_b = MB_BITS'(rad_y_ff);
         end
         mer_pkg::MUL_RX2_RY: begin
            mul_a = rx2_ff;
            mul_b = MB_BITS'(rad_y_ff);
         end
         mer_pkg::MUL_TX_SQ: begin
            mul_a = SQ_BITS'(tx);
            mul_b = MB_BITS'(tx);
         end
         mer_pkg::MUL_RY2_PROD: begin
            mul_a = ry2_ff;
            mul_b = prod_ff[MB_BITS-1:0];
         end
         mer_pkg::MUL_YM_SQ: begin
            mul_a = SQ_BITS'(ym_abs);
            mul_b = MB_BITS'(ym_abs);
         end
         mer_pkg::MUL_RX2_PROD: begin
            mul_a = rx2_ff;
            mul_b = prod_ff[MB_BITS-1:0];
         end
         mer_pkg::MUL_RX2_RY2: begin
            mul_a = rx2_ff;
            mul_b = MB_BITS'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = DEC_BITS'(mul_a) * DEC_BITS'(mul_b);

   // Per-point increments; decision values are kept scaled by four.
   assign rx2_ext = DEC_BITS'(rx2_ff);
   assign ry2_ext = DEC_BITS'(ry2_ff);
   assign sx_next = step_x_ff + (ry2_ext << 1);
   assign sy_next = step_y_ff - (rx2_ext << 1);
   assign dec_r1_up   = dec_ff + (sx_next << 2) + (ry2_ext << 2);
   assign dec_r1_diag = dec_ff + (sx_next << 2) - (sy_next << 2) + (ry2_ext << 2);
   assign dec_r2_down = dec_ff + (rx2_ext << 2) - (sy_next << 2);
   assign dec_r2_diag = dec_ff + (sx_next << 2) - (sy_next << 2) + (rx2_ext << 2);
   assign dec_neg = dec_ff[DEC_BITS-1];
   assign dec_pos = !dec_ff[DEC_BITS-1] && (dec_ff != '0);

   // Mirrored pixel coordinates of the current point.
   assign sum_right = SUM_BITS'(cen_x_ff) + SUM_BITS'(cur_x_ff);
   assign sum_left  = SUM_BITS'(cen_x_ff) - SUM_BITS'(cur_x_ff);
   assign sum_lower = SUM_BITS'(cen_y_ff) + SUM_BITS'(cur_y_ff);
   assign sum_upper = SUM_BITS'(cen_y_ff) - SUM_BITS'(cur_y_ff);

   assign out_free = !out_valid_ff || rsp_ready;

   // Status back to the controller.
   always_comb begin
      status.x_below_y   = $signed(step_x_ff) < $signed(step_y_ff);
      status.y_exhausted = ym[CUR_BITS];
      status.out_free    = out_free;
   end

   // Geometry, walk state and product registers.
   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      if (cmd.load_start) begin
         rad_x_ff  <= req_radius_x;
         rad_y_ff  <= req_radius_y;
         cen_x_ff  <= req_centre_x;
         cen_y_ff  <= req_centre_y;
         cur_x_ff  <= '0;
         cur_y_ff  <= CUR_BITS'(req_radius_y);
         step_x_ff <= '0;
      end
      case (cmd.acc_op)
         mer_pkg::ACC_SAVE_RX2: rx2_ff <= prod_ff[SQ_BITS-1:0];
         mer_pkg::ACC_SAVE_RY2: ry2_ff <= prod_ff[SQ_BITS-1:0];
         mer_pkg::ACC_INIT_R1: begin
            step_y_ff <= prod_ff << 1;
            dec_ff    <= (ry2_ext << 2) - (prod_ff << 2) + rx2_ext;
         end
         mer_pkg::ACC_LOAD_DEC: dec_ff <= prod_ff;
         mer_pkg::ACC_ADD_DEC:  dec_ff <= dec_ff + (prod_ff << 2);
         mer_pkg::ACC_SUB_DEC:  dec_ff <= dec_ff - (prod_ff << 2);
         default: ;
      endcase
      // Region 1: x always advances, y only on a non-negative decision.
      if (cmd.step_r1) begin
         cur_x_ff  <= cur_x_ff + CUR_BITS'(1);
         step_x_ff <= sx_next;
         if (dec_neg) begin
            dec_ff <= dec_r1_up;
         end else begin
            cur_y_ff  <= cur_y_ff - CUR_BITS'(1);
            step_y_ff <= sy_next;
            dec_ff    <= dec_r1_diag;
         end
      end
      // Region 2: y always drops, x only on a non-positive decision.
      if (cmd.step_r2) begin
         cur_y_ff  <= cur_y_ff - CUR_BITS'(1);
         step_y_ff <= sy_next;
         if (dec_pos) begin
            dec_ff <= dec_r2_down;
         end else begin
            cur_x_ff  <= cur_x_ff + CUR_BITS'(1);
            step_x_ff <= sx_next;
            dec_ff    <= dec_r2_diag;
         end
      end
   end

   // Output register: loaded on a step, emptied when the beat is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.step_r1 || cmd.step_r2) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step_r1 || cmd.step_r2) begin
         out_right_ff <= sum_right[OUT_BITS-1:0];
         out_left_ff  <= sum_left[OUT_BITS-1:0];
         out_lower_ff <= sum_lower[OUT_BITS-1:0];
         out_upper_ff <= sum_upper[OUT_BITS-1:0];
         out_last_ff  <= cmd.step_r2 && ym[CUR_BITS];
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_px_right   = out_right_ff;
   assign rsp_px_left    = out_left_ff;
   assign rsp_py_lower   = out_lower_ff;
   assign rsp_py_upper   = out_upper_ff;
   assign rsp_last_point = out_last_ff;

endmodule

FILE: hw/rtl/mer_controller.sv
// Controller: sequences start set-up, point steps and the region-2 entry.
module mer_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_command,
   output logic                   req_ready,
   output mer_pkg::dp_cmd_type    cmd,
   input  mer_pkg::dp_status_type status
);

   typedef enum logic [3:0] {
      ST_READY,
      ST_STEP,
      ST_CHECK,
      ST_RX2,
      ST_RY2,
      ST_P,
      ST_INIT,
      ST_EN_TX,
      ST_EN_A,
      ST_EN_YM,
      ST_EN_B,
      ST_EN_C,
      ST_EN_D
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_R1,
      PH_R2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;

   // Next state, phase and datapath commands.
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      req_ready      = 1'b0;
      cmd.load_start = 1'b0;
      cmd.mul_sel    = mer_pkg::MUL_RX_SQ;
      cmd.acc_op     = mer_pkg::ACC_NONE;
      cmd.step_r1    = 1'b0;
      cmd.step_r2    = 1'b0;
      case (state_ff)
         ST_READY: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_command == mer_pkg::COMMAND_START) begin
                  cmd.load_start = 1'b1;
                  state_in       = ST_RX2;
               end else if (phase_ff != PH_IDLE) begin
                  state_in = ST_STEP;
               end
            end
         end
         ST_STEP: begin
            // Wait here until the output register can take the point.
            if (status.out_free) begin
               if (phase_ff == PH_R1) begin
                  cmd.step_r1 = 1'b1;
                  state_in    = ST_CHECK;
               end else begin
                  cmd.step_r2 = 1'b1;
                  if (status.y_exhausted) begin
                     phase_in = PH_IDLE;
                  end
                  state_in = ST_READY;
               end
            end
         end
         ST_CHECK: begin
            state_in = status.x_below_y ? ST_READY : ST_EN_TX;
         end
         ST_RX2: begin
            cmd.mul_sel = mer_pkg::MUL_RX_SQ;
            state_in    = ST_RY2;
         end
         ST_RY2: begin
            cmd.mul_sel = mer_pkg::MUL_RY_SQ;
            cmd.acc_op  = mer_pkg::ACC_SAVE_RX2;
            state_in    = ST_P;
         end
         ST_P: begin
            cmd.mul_sel = mer_pkg::MUL_RX2_RY;
            cmd.acc_op  = mer_pkg::ACC_SAVE_RY2;
            state_in    = ST_INIT;
         end
         ST_INIT: begin
            cmd.acc_op = mer_pkg::ACC_INIT_R1;
            phase_in   = PH_R1;
            state_in   = ST_CHECK;
         end
         // Region-2 decision value, one product per cycle.
         ST_EN_TX: begin
            cmd.mul_sel = mer_pkg::MUL_TX_SQ;
            state_in    = ST_EN_A;
         end
         ST_EN_A: begin
            cmd.mul_sel = mer_pkg::MUL_RY2_PROD;
            state_in    = ST_EN_YM;
         end
         ST_EN_YM: begin
            cmd.mul_sel = mer_pkg::MUL_YM_SQ;
            cmd.acc_op  = mer_pkg::ACC_LOAD_DEC;
            state_in    = ST_EN_B;
         end
         ST_EN_B: begin
            cmd.mul_sel = mer_pkg::MUL_RX2_PROD;
            state_in    = ST_EN_C;
         end
         ST_EN_C: begin
            cmd.mul_sel = mer_pkg::MUL_RX2_RY2;
            cmd.acc_op  = mer_pkg::ACC_ADD_DEC;
            state_in    = ST_EN_D;
         end
         ST_EN_D: begin
            cmd.acc_op = mer_pkg::ACC_SUB_DEC;
            phase_in   = PH_R2;
            state_in   = ST_READY;
         end
         default: begin
            state_in = ST_READY;
         end
      endcase
   end

   // State and phase registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_READY;
         phase_ff <= PH_IDLE;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: hw/rtl/midpoint_ellipse_rasterizer.sv
// Top level of the midpoint ellipse rasterizer.
//
// A start beat loads radii and centre and gives no response; each step beat then
// gives one response beat holding the four mirrored pixels of the next point of
// the quadrant, the final point flagged by last_point, and steps while no
// ellipse is being drawn give nothing. A start forms the squared radii and the
// initial decision value, and also the region-2 decision value when the walk
// begins directly in region 2; the step that crosses into region 2 forms it too,
// and a region-1 step also checks the region boundary. The single shared
// multiplier forms these products one per cycle. Finished points wait in an
// output register, so new beats are taken while a response is pending; a step
// only holds when that register is still full.
module midpoint_ellipse_rasterizer #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input logic    clock,
   input logic    reset,
   mer_req_if.sink   req_bus,
   mer_rsp_if.source rsp_bus
);

   mer_pkg::dp_cmd_type    cmd;
   mer_pkg::dp_status_type status;

   // Sequencer.
   mer_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_ready   (req_bus.ready),
      .cmd         (cmd),
      .status      (status)
   );

   // Arithmetic and output register.
   mer_datapath #(
      .RADIUS_BITS (RADIUS_BITS),
      .COORD_BITS  (COORD_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_radius_x   (req_bus.radius_x),
      .req_radius_y   (req_bus.radius_y),
      .req_centre_x   (req_bus.centre_x),
      .req_centre_y   (req_bus.centre_y),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_px_right   (rsp_bus.px_right),
      .rsp_px_left    (rsp_bus.px_left),
      .rsp_py_lower   (rsp_bus.py_lower),
      .rsp_py_upper   (rsp_bus.py_upper),
      .rsp_last_point (rsp_bus.last_point)
   );

endmodule

FILE: sim/midpoint_ellipse_rasterizer_tb.sv
// Self-checking testbench of the midpoint ellipse rasterizer: directed and random walks.
module midpoint_ellipse_rasterizer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RADIUS_BITS    = 10;
   localparam int COORD_BITS     = 11;
   localparam int OUT_BITS       = COORD_BITS + 2;
   localparam int STALL_LIMIT    = 1000;
   localparam int SETTLE_CYCLES  = 24;
   localparam int TOTAL_BEATS    = 1350;
   localparam int MISMATCH_SHOWN = 10;

   typedef enum logic [1:0] {ARC_IDLE, ARC_REGION1, ARC_REGION2} arc_phase_type;

   typedef struct packed {
      logic signed [OUT_BITS-1:0] px_right;
      logic signed [OUT_BITS-1:0] px_left;
      logic signed [OUT_BITS-1:0] py_lower;
      logic signed [OUT_BITS-1:0] py_upper;
      logic                       last_point;
   } pixel_point_type;

   logic clock;
   logic reset;

   mer_req_if #(.RADIUS_BITS(RADIUS_BITS), .COORD_BITS(COORD_BITS)) req_bus ();
   mer_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   midpoint_ellipse_rasterizer #(
      .RADIUS_BITS(RADIUS_BITS),
      .COORD_BITS (COORD_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // Predicted walk state, all arithmetic modulo 2^64.
   arc_phase_type   arc_phase;
   logic [63:0]     pt_x, pt_y, dec_val, grad_x, grad_y;
   logic [63:0]     geo_rx, geo_ry, geo_cx, geo_cy;
   pixel_point_type pending_points[$];

   int  mismatches;
   int  beats_sent;
   int  idle_cycles;
   int  send_run;
   int  take_run;
   bit  req_live;
   bit  rsp_live;

   // 10 ns clock.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Watchdog: too long without any beat on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Draws a random wait before a beat, with occasional stretches of back-to-back beats.
   task automatic pick_gap(inout int run_left, output int gap);
      if (run_left > 0) begin
         run_left--;
         gap = 0;
      end else if ($urandom_range(0, 15) == 0) begin
         run_left = $urandom_range(8, 40);
         gap = 0;
      end else begin
         gap = $urandom_range(0, 9);
      end
   endtask

   function automatic logic [OUT_BITS-1:0] low_coord(input logic [63:0] v);
      return v[OUT_BITS-1:0];
   endfunction

   // Switches the predicted walk to the second region with its scaled decision value.
   task automatic begin_lower_arc();
      logic [63:0] rx_sq, ry_sq, tx, ym;
      rx_sq   = geo_rx * geo_rx;
      ry_sq   = geo_ry * geo_ry;
      tx      = 64'd2 * pt_x + 64'd1;
      ym      = pt_y - 64'd1;
      dec_val = ry_sq * tx * tx + 64'd4 * rx_sq * ym * ym - 64'd4 * rx_sq * ry_sq;
      arc_phase = ARC_REGION2;
   endtask

   // Works out what one accepted request beat causes and queues the point, if any.
   task automatic predict_beat(input logic cmd, input logic [RADIUS_BITS-1:0] rx,
                               input logic [RADIUS_BITS-1:0] ry,
                               input logic [COORD_BITS-1:0] cx,
                               input logic [COORD_BITS-1:0] cy);
      logic [63:0]     rx_sq, ry_sq;
      pixel_point_type pt;
      if (cmd == mer_pkg::COMMAND_START) begin
         geo_rx  = {{(64-RADIUS_BITS){1'b0}}, rx};
         geo_ry  = {{(64-RADIUS_BITS){1'b0}}, ry};
         geo_cx  = {{(64-COORD_BITS){1'b0}}, cx};
         geo_cy  = {{(64-COORD_BITS){1'b0}}, cy};
         rx_sq   = geo_rx * geo_rx;
         ry_sq   = geo_ry * geo_ry;
         pt_x    = 64'd0;
         pt_y    = geo_ry;
         grad_x  = 64'd0;
         grad_y  = 64'd2 * rx_sq * pt_y;
         dec_val = 64'd4 * ry_sq - 64'd4 * rx_sq * geo_ry + rx_sq;
         arc_phase = ARC_REGION1;
         // A flat start may already be past the region boundary.
         if (!($signed(grad_x) < $signed(grad_y))) begin
            begin_lower_arc();
         end
      end else if (arc_phase != ARC_IDLE) begin
         pt.px_right   = low_coord(geo_cx + pt_x);
         pt.px_left    = low_coord(geo_cx - pt_x);
         pt.py_lower   = low_coord(geo_cy + pt_y);
         pt.py_upper   = low_coord(geo_cy - pt_y);
         pt.last_point = 1'b0;
         rx_sq = geo_rx * geo_rx;
         ry_sq = geo_ry * geo_ry;
         if (arc_phase == ARC_REGION1) begin
            pt_x   = pt_x + 64'd1;
            grad_x = grad_x + 64'd2 * ry_sq;
            if ($signed(dec_val) < 0) begin
               dec_val = dec_val + 64'd4 * grad_x + 64'd4 * ry_sq;
            end else begin
               pt_y    = pt_y - 64'd1;
               grad_y  = grad_y - 64'd2 * rx_sq;
               dec_val = dec_val + 64'd4 * grad_x - 64'd4 * grad_y + 64'd4 * ry_sq;
            end
            if (!($signed(grad_x) < $signed(grad_y))) begin
               begin_lower_arc();
            end
         end else begin
            pt_y   = pt_y - 64'd1;
            grad_y = grad_y - 64'd2 * rx_sq;
            if ($signed(dec_val) > 0) begin
               dec_val = dec_val + 64'd4 * rx_sq - 64'd4 * grad_y;
            end else begin
               pt_x    = pt_x + 64'd1;
               grad_x  = grad_x + 64'd2 * ry_sq;
               dec_val = dec_val + 64'd4 * grad_x - 64'd4 * grad_y + 64'd4 * rx_sq;
            end
            // The walk ends once y has dropped below zero.
            if ($signed(pt_y) < 0) begin
               pt.last_point = 1'b1;
               arc_phase = ARC_IDLE;
            end
         end
         pending_points.push_back(pt);
      end
   endtask

   // Sends one request beat; valid stays high only when the next beat follows at once.
   task automatic send_beat(input logic cmd, input logic [RADIUS_BITS-1:0] rx,
                            input logic [RADIUS_BITS-1:0] ry,
                            input logic [COORD_BITS-1:0] cx,
                            input logic [COORD_BITS-1:0] cy);
      int gap;
      pick_gap(send_run, gap);
      if (gap > 0) begin
         if (req_live) begin
            req_bus.valid <= 1'b0;
         end
         req_live = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.command  <= cmd;
      req_bus.radius_x <= rx;
      req_bus.radius_y <= ry;
      req_bus.centre_x <= cx;
      req_bus.centre_y <= cy;
      req_live = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_beat(cmd, rx, ry, cx, cy);
      beats_sent++;
   endtask

   // A beat whose geometry fields are arbitrary; on a step they are ignored.
   task automatic send_scrambled(input logic cmd);
      logic [31:0] r0, r1;
      r0 = $urandom;
      r1 = $urandom;
      send_beat(cmd, r0[9:0], r0[19:10], r1[10:0], r1[21:11]);
   endtask

   function automatic logic [RADIUS_BITS-1:0] pick_radius(input int top);
      logic [31:0] r;
      r = $urandom_range(0, top);
      return r[RADIUS_BITS-1:0];
   endfunction

   // Holds the sender back until every predicted point has been taken.
   task automatic wait_drained();
      if (req_live) begin
         req_bus.valid <= 1'b0;
      end
      req_live = 1'b0;
      @(posedge clock);
      while (pending_points.size() != 0) @(posedge clock);
   endtask

   // Compares one accepted point beat with the oldest prediction.
   task automatic check_point();
      pixel_point_type want, got;
      string           diff;
      got.px_right   = rsp_bus.px_right;
      got.px_left    = rsp_bus.px_left;
      got.py_lower   = rsp_bus.py_lower;
      got.py_upper   = rsp_bus.py_upper;
      got.last_point = rsp_bus.last_point;
      if (pending_points.size() == 0) begin
         mismatches++;
         if (mismatches <= MISMATCH_SHOWN) begin
            $display("unexpected point beat: right=%0d left=%0d lower=%0d upper=%0d last=%0b",
                     got.px_right, got.px_left, got.py_lower, got.py_upper, got.last_point);
         end
      end else begin
         want = pending_points.pop_front();
         diff = "";
         if (got.px_right !== want.px_right) diff = {diff, " px_right"};
         if (got.px_left !== want.px_left) diff = {diff, " px_left"};
         if (got.py_lower !== want.py_lower) diff = {diff, " py_lower"};
         if (got.py_upper !== want.py_upper) diff = {diff, " py_upper"};
         if (got.last_point !== want.last_point) diff = {diff, " last_point"};
         if (diff != "") begin
            mismatches++;
            if (mismatches <= MISMATCH_SHOWN) begin
               $display("point mismatch in%s: expected %0d %0d %0d %0d %0b, got %0d %0d %0d %0d %0b",
                        diff, want.px_right, want.px_left, want.py_lower, want.py_upper,
                        want.last_point, got.px_right, got.px_left, got.py_lower,
                        got.py_upper, got.last_point);
            end
         end
      end
   endtask

   // Response side: random stalls, each accepted beat checked.
   initial begin
      int gap;
      rsp_bus.ready <= 1'b0;
      rsp_live = 1'b0;
      take_run = 0;
      @(posedge clock);
      forever begin
         pick_gap(take_run, gap);
         if (gap > 0) begin
            if (rsp_live) begin
               rsp_bus.ready <= 1'b0;
            end
            rsp_live = 1'b0;
            repeat (gap) @(posedge clock);
         end
         if (!rsp_live) begin
            rsp_bus.ready <= 1'b1;
         end
         rsp_live = 1'b1;
         @(posedge clock);
         while (!(rsp_bus.valid && !reset)) @(posedge clock);
         check_point();
      end
   end

   // Steps with no ellipse loaded give nothing.
   task automatic test_idle_steps();
      repeat (3) send_scrambled(mer_pkg::COMMAND_STEP);
   endtask

   // Zero radii: a zero vertical radius gives one point flagged last, and steps after
   // the last point give nothing.
   task automatic test_zero_radii();
      send_beat(mer_pkg::COMMAND_START, 10'd5, 10'd0, 11'd100, 11'd200);
      repeat (2) send_scrambled(mer_pkg::COMMAND_STEP);
      send_beat(mer_pkg::COMMAND_START, 10'd0, 10'd2, 11'd7, 11'd9);
      repeat (3) send_scrambled(mer_pkg::COMMAND_STEP);
      send_beat(mer_pkg::COMMAND_START, 10'd0, 10'd0, 11'd2047, 11'd0);
      send_scrambled(mer_pkg::COMMAND_STEP);
   endtask

   // Largest radii and centres at both ends, each walk abandoned by the next start.
   task automatic test_extreme_geometry();
      send_beat(mer_pkg::COMMAND_START, 10'd1023, 10'd1023, 11'd2047, 11'd2047);
      repeat (2) send_scrambled(mer_pkg::COMMAND_STEP);
      send_beat(mer_pkg::COMMAND_START, 10'd1023, 10'd1023, 11'd0, 11'd0);
      repeat (2) send_scrambled(mer_pkg::COMMAND_STEP);
      // A narrow, tall ellipse crosses into the second region on its first step.
      send_beat(mer_pkg::COMMAND_START, 10'd1, 10'd1023, 11'd0, 11'd2047);
      repeat (3) send_scrambled(mer_pkg::COMMAND_STEP);
      send_beat(mer_pkg::COMMAND_START, 10'd1023, 10'd1, 11'd2047, 11'd0);
      repeat (2) send_scrambled(mer_pkg::COMMAND_STEP);
   endtask

   // The sender waits for every point in the middle of a walk, then carries on.
   task automatic test_pause_for_results();
      send_beat(mer_pkg::COMMAND_START, 10'd7, 10'd4, 11'd300, 11'd400);
      repeat (6) send_scrambled(mer_pkg::COMMAND_STEP);
      wait_drained();
      repeat (6) send_scrambled(mer_pkg::COMMAND_STEP);
   endtask

   // Mostly complete walks of small ellipses, some cut short, a few huge, some noise.
   task automatic test_random_walks();
      int          mode, cut;
      logic [31:0] r;
      logic [RADIUS_BITS-1:0] rx, ry;
      while (beats_sent < TOTAL_BEATS) begin
         mode = $urandom_range(0, 19);
         if (mode < 2) begin
            repeat ($urandom_range(1, 6)) begin
               r = $urandom;
               send_scrambled(r[0]);
            end
         end else begin
            if (mode < 4) begin
               rx = pick_radius(1023);
               ry = pick_radius(1023);
            end else if (mode < 7) begin
               rx = pick_radius(63);
               ry = pick_radius(63);
            end else begin
               rx = pick_radius(15);
               ry = pick_radius(15);
            end
            r = $urandom;
            send_beat(mer_pkg::COMMAND_START, rx, ry, r[10:0], r[21:11]);
            // Large walks are always abandoned early; small ones now and then.
            if (mode < 4 || $urandom_range(0, 5) == 0) begin
               cut = $urandom_range(1, 12);
            end else begin
               cut = 1 << 20;
            end
            while (arc_phase != ARC_IDLE && cut > 0) begin
               send_scrambled(mer_pkg::COMMAND_STEP);
               cut--;
            end
            repeat ($urandom_range(0, 2)) send_scrambled(mer_pkg::COMMAND_STEP);
         end
         if ($urandom_range(0, 24) == 0) begin
            wait_drained();
         end
      end
   endtask

   // Reset, tests in turn, drain and verdict.
   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.command  <= mer_pkg::COMMAND_START;
      req_bus.radius_x <= '0;
      req_bus.radius_y <= '0;
      req_bus.centre_x <= '0;
      req_bus.centre_y <= '0;
      req_live   = 1'b0;
      send_run   = 0;
      mismatches = 0;
      beats_sent = 0;
      idle_cycles = 0;
      arc_phase = ARC_IDLE;
      pt_x = '0; pt_y = '0; dec_val = '0; grad_x = '0; grad_y = '0;
      geo_rx = '0; geo_ry = '0; geo_cx = '0; geo_cy = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_idle_steps();
      test_zero_radii();
      test_extreme_geometry();
      test_pause_for_results();
      test_random_walks();

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_points.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
